[hw/rtl/hgpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgpr_pkg
// Shared types, codes and the 5x8 hex glyph ROM for the glyph renderer.
// ----------------------------------------------------------------------------
package hgpr_pkg;

    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 8;
    localparam int COL_W      = $clog2(GLYPH_COLS);
    localparam int ROW_W      = $clog2(GLYPH_ROWS);

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(GLYPH_COLS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);

    localparam logic [7:0] ROW_SPAN = 8'(GLYPH_ROWS - 1);
    localparam logic [7:0] COL_SPAN = 8'(GLYPH_COLS - 1);

    localparam logic [1:0] KIND_ROW_WIN = 2'd0;
    localparam logic [1:0] KIND_COL_WIN = 2'd1;
    localparam logic [1:0] KIND_PIXEL   = 2'd2;

    localparam logic [7:0] GLYPH_ROM [16][GLYPH_COLS] = '{
        '{8'h7e, 8'h89, 8'h91, 8'ha1, 8'h7e},
        '{8'h00, 8'h41, 8'hff, 8'h01, 8'h00},
        '{8'h43, 8'h85, 8'h89, 8'h91, 8'h61},
        '{8'h42, 8'h81, 8'h91, 8'h91, 8'h6e},
        '{8'h18, 8'h28, 8'h48, 8'hff, 8'h08},
        '{8'hf2, 8'h91, 8'h91, 8'h91, 8'h8e},
        '{8'h1e, 8'h29, 8'h49, 8'h89, 8'h86},
        '{8'h80, 8'h8f, 8'h90, 8'ha0, 8'hc0},
        '{8'h6e, 8'h91, 8'h91, 8'h91, 8'h6e},
        '{8'h70, 8'h89, 8'h89, 8'h8a, 8'h7c},
        '{8'h7f, 8'h88, 8'h88, 8'h88, 8'h7f},
        '{8'hff, 8'h91, 8'h91, 8'h91, 8'h6e},
        '{8'h7e, 8'h81, 8'h81, 8'h81, 8'h42},
        '{8'hff, 8'h81, 8'h81, 8'h42, 8'h3c},
        '{8'hff, 8'h91, 8'h91, 8'h91, 8'h81},
        '{8'hff, 8'h90, 8'h90, 8'h90, 8'h80}
    };

    typedef struct packed {
        logic [3:0] digit;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] fg_red;
        logic [7:0] fg_green;
        logic [7:0] fg_blue;
        logic [7:0] background;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] window_start;
        logic [7:0] window_end;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [GLYPH_COLS-1:0][7:0] cols;
        logic [7:0]                 row_start;
        logic [7:0]                 row_end;
        logic [7:0]                 col_start;
        logic [7:0]                 col_end;
        logic [7:0]                 fg_red;
        logic [7:0]                 fg_green;
        logic [7:0]                 fg_blue;
        logic [7:0]                 background;
    } job_t;

endpackage

[hw/rtl/hgpr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgpr_front
// Accepts draw requests, fetches the glyph columns and computes the windows.
// ----------------------------------------------------------------------------
module hgpr_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hgpr_pkg::in_item_t s_item,
    output logic              job_valid,
    input  logic              job_ready,
    output hgpr_pkg::job_t    job
);
    import hgpr_pkg::*;

    logic job_valid_reg;
    job_t job_reg;
    job_t job_next;

    assign s_ready   = !job_valid_reg || job_ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb begin
        for (int c = 0; c < GLYPH_COLS; c++) begin
            job_next.cols[c] = GLYPH_ROM[s_item.digit][c];
        end
        job_next.row_start  = s_item.pos_y;
        job_next.row_end    = s_item.pos_y + ROW_SPAN;
        job_next.col_start  = s_item.pos_x;
        job_next.col_end    = s_item.pos_x + COL_SPAN;
        job_next.fg_red     = s_item.fg_red;
        job_next.fg_green   = s_item.fg_green;
        job_next.fg_blue    = s_item.fg_blue;
        job_next.background = s_item.background;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            job_valid_reg <= 1'b1;
        end else if (job_ready) begin
            job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            job_reg <= job_next;
        end
    end

endmodule

[hw/rtl/hgpr_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgpr_queue
// Two-entry job queue between the request front end and the pixel sequencer.
// ----------------------------------------------------------------------------
module hgpr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  hgpr_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop,
    output hgpr_pkg::job_t pop_job
);
    import hgpr_pkg::*;

    job_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hw/rtl/hgpr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgpr_back
// Sequencer: emits the row window, the column window and forty pixels.
// ----------------------------------------------------------------------------
module hgpr_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               job_valid,
    output logic               job_pop,
    input  hgpr_pkg::job_t     job,
    output logic               m_valid,
    input  logic               m_ready,
    output hgpr_pkg::out_item_t m_item
);
    import hgpr_pkg::*;

    localparam logic [1:0] ST_ROW_WIN = 2'd0;
    localparam logic [1:0] ST_COL_WIN = 2'd1;
    localparam logic [1:0] ST_PIXEL   = 2'd2;

    logic             active_reg;
    logic [1:0]       state_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    job_t             job_reg;
    logic             m_valid_reg;
    out_item_t        m_item_reg;
    out_item_t        item_next;
    logic             advance;
    logic             at_end;
    logic             lit;

    assign advance = !m_valid_reg || m_ready;
    assign at_end  = (state_reg == ST_PIXEL) && (row_reg == ROW_LAST) && (col_reg == COL_LAST);
    assign job_pop = job_valid && (!active_reg || (advance && at_end));
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;
    assign lit     = job_reg.cols[col_reg][ROW_LAST - row_reg];

    always_comb begin
        item_next = '0;
        unique case (state_reg)
            ST_ROW_WIN: begin
                item_next.kind         = KIND_ROW_WIN;
                item_next.window_start = job_reg.row_start;
                item_next.window_end   = job_reg.row_end;
            end
            ST_COL_WIN: begin
                item_next.kind         = KIND_COL_WIN;
                item_next.window_start = job_reg.col_start;
                item_next.window_end   = job_reg.col_end;
            end
            ST_PIXEL: begin
                item_next.kind  = KIND_PIXEL;
                item_next.red   = lit ? job_reg.fg_red   : job_reg.background;
                item_next.green = lit ? job_reg.fg_green : job_reg.background;
                item_next.blue  = lit ? job_reg.fg_blue  : job_reg.background;
                item_next.last  = at_end;
            end
            default: begin
                item_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            state_reg   <= ST_ROW_WIN;
            row_reg     <= '0;
            col_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                m_valid_reg <= active_reg;
            end
            if (job_pop) begin
                active_reg <= 1'b1;
                state_reg  <= ST_ROW_WIN;
                row_reg    <= '0;
                col_reg    <= '0;
            end else if (active_reg && advance) begin
                unique case (state_reg)
                    ST_ROW_WIN: state_reg <= ST_COL_WIN;
                    ST_COL_WIN: state_reg <= ST_PIXEL;
                    ST_PIXEL: begin
                        if (at_end) begin
                            active_reg <= 1'b0;
                        end else if (col_reg == COL_LAST) begin
                            col_reg <= '0;
                            row_reg <= row_reg + 1'b1;
                        end else begin
                            col_reg <= col_reg + 1'b1;
                        end
                    end
                    default: state_reg <= ST_ROW_WIN;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            job_reg <= job;
        end
        if (advance && active_reg) begin
            m_item_reg <= item_next;
        end
    end

endmodule

[hw/rtl/hex_glyph_pixel_renderer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_glyph_pixel_renderer_top
// 5x8 hex digit renderer: window items followed by forty pixels per request.
// ----------------------------------------------------------------------------
// Each request draws one hex digit and yields 42 results: the row window, the
// column window, then 40 pixels row by row with last set on the final one.
// Results leave the output register one per cycle while the receiver is ready;
// a front stage and a two-entry queue take the next requests meanwhile, so
// back-to-back requests stream without gaps. After idle a request passes the
// front register, the queue, the sequencer's job register and the output register.
module hex_glyph_pixel_renderer_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hgpr_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output hgpr_pkg::out_item_t m_item
);
    import hgpr_pkg::*;

    logic f_valid;
    logic f_ready;
    job_t f_job;
    logic q_valid;
    logic q_pop;
    job_t q_job;

    hgpr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    hgpr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_job    (q_job)
    );

    hgpr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_valid),
        .job_pop   (q_pop),
        .job       (q_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

[hw/rtl/hgpr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgpr_checker
// Port-level assertions for the hex glyph renderer, bound to the top level.
// ----------------------------------------------------------------------------
module hgpr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input hgpr_pkg::out_item_t m_item
);
    import hgpr_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    a_row_then_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_item.kind == KIND_ROW_WIN
        |=> m_valid && m_item.kind == KIND_COL_WIN)
        else $error("column window does not follow row window");

    a_row_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.kind == KIND_ROW_WIN
        |-> m_item.window_end == 8'(m_item.window_start + ROW_SPAN))
        else $error("row window span wrong");

    a_pixel_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.kind == KIND_PIXEL
        |-> m_item.window_start == 8'd0 && m_item.window_end == 8'd0)
        else $error("pixel carries window data");

    a_window_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.kind != KIND_PIXEL
        |-> m_item.red == 8'd0 && m_item.green == 8'd0 && m_item.blue == 8'd0
            && !m_item.last)
        else $error("window item carries pixel data");

endmodule

bind hex_glyph_pixel_renderer_top hgpr_checker u_hgpr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for hex_glyph_pixel_renderer_top.
// ----------------------------------------------------------------------------
// Each accepted request is expanded into its expected stream: the row window,
// the column window and 40 pixels lit from a local copy of the hex font.
// Results are checked in order, field by field. Directed requests cover all
// digits, window wrap and color extremes. Random requests then run in phases
// of sender idling and receiver stalls. One long receiver hold-off backs up
// the block while requests keep coming.
// ----------------------------------------------------------------------------
module testbench;
    import hgpr_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 20;
    localparam int PHASE_REQS   = 37;
    localparam int PRINT_CAP    = 40;

    // 5 column bytes per digit, bit 7 is the top row
    localparam logic [7:0] HEX_FONT [80] = '{
        8'h7e, 8'h89, 8'h91, 8'ha1, 8'h7e,
        8'h00, 8'h41, 8'hff, 8'h01, 8'h00,
        8'h43, 8'h85, 8'h89, 8'h91, 8'h61,
        8'h42, 8'h81, 8'h91, 8'h91, 8'h6e,
        8'h18, 8'h28, 8'h48, 8'hff, 8'h08,
        8'hf2, 8'h91, 8'h91, 8'h91, 8'h8e,
        8'h1e, 8'h29, 8'h49, 8'h89, 8'h86,
        8'h80, 8'h8f, 8'h90, 8'ha0, 8'hc0,
        8'h6e, 8'h91, 8'h91, 8'h91, 8'h6e,
        8'h70, 8'h89, 8'h89, 8'h8a, 8'h7c,
        8'h7f, 8'h88, 8'h88, 8'h88, 8'h7f,
        8'hff, 8'h91, 8'h91, 8'h91, 8'h6e,
        8'h7e, 8'h81, 8'h81, 8'h81, 8'h42,
        8'hff, 8'h81, 8'h81, 8'h42, 8'h3c,
        8'hff, 8'h91, 8'h91, 8'h91, 8'h81,
        8'hff, 8'h90, 8'h90, 8'h90, 8'h80
    };

    class glyph_scoreboard;
        out_item_t   pixel_stream_q[$];
        int unsigned faults;

        function new();
            faults = 0;
        endfunction

        function void note_request(in_item_t req);
            out_item_t  exp_item;
            logic [7:0] col_bits;
            exp_item              = '0;
            exp_item.kind         = KIND_ROW_WIN;
            exp_item.window_start = req.pos_y;
            exp_item.window_end   = req.pos_y + 8'd7;
            pixel_stream_q.push_back(exp_item);
            exp_item.kind         = KIND_COL_WIN;
            exp_item.window_start = req.pos_x;
            exp_item.window_end   = req.pos_x + 8'd4;
            pixel_stream_q.push_back(exp_item);
            for (int row = 0; row < 8; row++) begin
                for (int col = 0; col < 5; col++) begin
                    col_bits = HEX_FONT[req.digit * 5 + col];
                    exp_item      = '0;
                    exp_item.kind = KIND_PIXEL;
                    if (col_bits[7 - row]) begin
                        exp_item.red   = req.fg_red;
                        exp_item.green = req.fg_green;
                        exp_item.blue  = req.fg_blue;
                    end else begin
                        exp_item.red   = req.background;
                        exp_item.green = req.background;
                        exp_item.blue  = req.background;
                    end
                    exp_item.last = (row == 7 && col == 4);
                    pixel_stream_q.push_back(exp_item);
                end
            end
        endfunction

        function void flag(string field, logic [7:0] exp_val, logic [7:0] got_val);
            faults++;
            if (faults <= PRINT_CAP)
                $display("%0t: %s mismatch: expected %h, got %h",
                         $time, field, exp_val, got_val);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_item;
            if (pixel_stream_q.size() == 0) begin
                faults++;
                if (faults <= PRINT_CAP)
                    $display("%0t: unexpected result: expected none, got %h", $time, got);
                return;
            end
            exp_item = pixel_stream_q.pop_front();
            if (got.kind !== exp_item.kind)
                flag("kind", 8'(exp_item.kind), 8'(got.kind));
            if (got.window_start !== exp_item.window_start)
                flag("window_start", exp_item.window_start, got.window_start);
            if (got.window_end !== exp_item.window_end)
                flag("window_end", exp_item.window_end, got.window_end);
            if (got.red !== exp_item.red)
                flag("red", exp_item.red, got.red);
            if (got.green !== exp_item.green)
                flag("green", exp_item.green, got.green);
            if (got.blue !== exp_item.blue)
                flag("blue", exp_item.blue, got.blue);
            if (got.last !== exp_item.last)
                flag("last", 8'(exp_item.last), 8'(got.last));
        endfunction

        function int pending();
            return pixel_stream_q.size();
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    glyph_scoreboard sb;
    int unsigned     cycle_count;
    int unsigned     idle_pct;
    int unsigned     stall_pct;
    bit              hold_go;
    int unsigned     hold_left;

    hex_glyph_pixel_renderer_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
    end

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("hex_glyph_pixel_renderer_top test failed");
            $finish;
        end
    end

    function automatic in_item_t make_request(logic [3:0] d, logic [7:0] x, logic [7:0] y,
                                              logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                              logic [7:0] bg);
        in_item_t req;
        req.digit      = d;
        req.pos_x      = x;
        req.pos_y      = y;
        req.fg_red     = r;
        req.fg_green   = g;
        req.fg_blue    = b;
        req.background = bg;
        return req;
    endfunction

    function automatic logic [7:0] random_coord();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(248, 255));
            1: return 8'($urandom_range(0, 7));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic in_item_t random_request();
        return make_request(4'($urandom_range(0, 15)), random_coord(), random_coord(),
                            8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    task automatic send_request(in_item_t req);
        int unsigned gap;
        gap = 0;
        while (gap < 50 && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // result side: checks each accepted result, then picks the next ready
    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_result(m_item);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_go) begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial begin
        sb          = new();
        cycle_count = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_go     = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_item      = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int d = 0; d < 16; d++)
            send_request(make_request(4'(d), 8'(d * 16), 8'(255 - d * 16),
                                      8'(d * 17), 8'(255 - d * 17), 8'(d * 5), 8'(d * 11)));
        // window ends at 255 exactly and just past it
        send_request(make_request(4'hb, 8'd251, 8'd248, 8'hff, 8'hff, 8'hff, 8'h00));
        send_request(make_request(4'h1, 8'd252, 8'd249, 8'h00, 8'h00, 8'h00, 8'hff));
        send_request(make_request(4'hf, 8'd255, 8'd255, 8'haa, 8'h55, 8'h0f, 8'hf0));
        send_request(make_request(4'h0, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        s_valid <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 72; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 72; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            for (int n = 0; n < PHASE_REQS; n++) begin
                if (ph == 0 && n == 10)
                    hold_go = 1'b1;
                send_request(random_request());
            end
            s_valid <= 1'b0;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.faults == 0 && sb.pending() == 0) begin
            $display("hex_glyph_pixel_renderer_top test passed");
        end else begin
            $display("hex_glyph_pixel_renderer_top test failed");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/hgpr_pkg.sv
hw/rtl/hgpr_front.sv
hw/rtl/hgpr_queue.sv
hw/rtl/hgpr_back.sv
hw/rtl/hex_glyph_pixel_renderer_top.sv
hw/rtl/hgpr_checker.sv
tb/testbench.sv
